### hdl/mex_pkg.sv
// Shared types and constants for the modular exponentiation core.
// Used by the channel interfaces, controller, datapath, top level and checker.
// No dependencies.
package mex_pkg;

   // Fixed field widths of the channels and the configuration register
   localparam int BASE_W     = 31;
   localparam int EXP_W      = 32;
   localparam int RESULT_W   = 31;
   localparam int MODULUS_W  = 31;

   localparam logic [MODULUS_W-1:0] MODULUS_RESET = 31'd1000000009;

   typedef logic [BASE_W-1:0]    base_type;
   typedef logic [EXP_W-1:0]     exponent_type;
   typedef logic [RESULT_W-1:0]  result_type;
   typedef logic [MODULUS_W-1:0] modulus_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;         // take a new item, set up base reduction
      logic red_step;     // one restoring reduction step
      logic base_store;   // reduced base into the base register
      logic mul_start;    // register one product
      logic mul_by_base;  // product operand is the base, else the running value
      logic prod_load;    // split the product into remainder and shift word
      logic acc_store;    // reduced product into the running value
      logic bit_next;     // advance to the next exponent bit
      logic out_load;     // hand the result to the output register
   } dp_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic red_done;     // reduction steps exhausted
      logic exp_msb;      // current exponent bit
      logic last_bit;     // current exponent bit is the final one
      logic mod_zero;     // modulus register holds zero
   } dp_status_type;

endpackage

### hdl/mex_channels.sv
// Valid/ready channel interfaces for the modular exponentiation core.
// Depends on mex_pkg for the payload types.
interface mex_req_if;
   import mex_pkg::*;

   logic         valid;
   logic         ready;
   base_type     base;
   exponent_type exponent;

   modport source (output valid, output base, output exponent, input ready);
   modport sink   (input valid, input base, input exponent, output ready);
endinterface

interface mex_rsp_if;
   import mex_pkg::*;

   logic       valid;
   logic       ready;
   result_type result;

   modport source (output valid, output result, input ready);
   modport sink   (input valid, input result, output ready);
endinterface

### hdl/mex_ctrl.sv
// Sequencing state machine for square-and-multiply.
// Depends on mex_pkg for the command and status structs.
module mex_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   out_free,
   input  mex_pkg::dp_status_type status,
   output logic                   req_ready,
   output mex_pkg::dp_cmd_type    cmd
);
   import mex_pkg::*;

   typedef enum logic [8:0] {
      ST_IDLE    = 9'b000000001,
      ST_RBASE   = 9'b000000010,
      ST_SQ_MUL  = 9'b000000100,
      ST_SQ_LOAD = 9'b000001000,
      ST_SQ_RED  = 9'b000010000,
      ST_BM_MUL  = 9'b000100000,
      ST_BM_LOAD = 9'b001000000,
      ST_BM_RED  = 9'b010000000,
      ST_DONE    = 9'b100000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = status.mod_zero ? ST_DONE : ST_RBASE;
            end
         end
         ST_RBASE: begin
            if (!status.red_done) begin
               cmd.red_step = 1'b1;
            end else begin
               cmd.base_store = 1'b1;
               state_in       = ST_SQ_MUL;
            end
         end
         ST_SQ_MUL: begin
            cmd.mul_start = 1'b1;
            state_in      = ST_SQ_LOAD;
         end
         ST_SQ_LOAD: begin
            cmd.prod_load = 1'b1;
            state_in      = ST_SQ_RED;
         end
         ST_SQ_RED: begin
            if (!status.red_done) begin
               cmd.red_step = 1'b1;
            end else begin
               cmd.acc_store = 1'b1;
               if (status.exp_msb) begin
                  state_in = ST_BM_MUL;
               end else begin
                  cmd.bit_next = 1'b1;
                  state_in     = status.last_bit ? ST_DONE : ST_SQ_MUL;
               end
            end
         end
         ST_BM_MUL: begin
            cmd.mul_start   = 1'b1;
            cmd.mul_by_base = 1'b1;
            state_in        = ST_BM_LOAD;
         end
         ST_BM_LOAD: begin
            cmd.prod_load = 1'b1;
            state_in      = ST_BM_RED;
         end
         ST_BM_RED: begin
            if (!status.red_done) begin
               cmd.red_step = 1'b1;
            end else begin
               cmd.acc_store = 1'b1;
               cmd.bit_next  = 1'b1;
               state_in      = status.last_bit ? ST_DONE : ST_SQ_MUL;
            end
         end
         ST_DONE: begin
            // hold the result until the output register is free
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### hdl/mex_datapath.sv
// Datapath: exponent shifter, running value, product register and a
// bit-serial restoring reduction unit. Depends on mex_pkg.
module mex_datapath #(
   parameter int EXP_WIDTH = 32,
   parameter int MOD_WIDTH = 31
) (
   input  logic                   clock,
   input  mex_pkg::dp_cmd_type    cmd,
   input  mex_pkg::base_type      req_base,
   input  mex_pkg::exponent_type  req_exponent,
   input  logic [MOD_WIDTH-1:0]   modulus,
   output mex_pkg::dp_status_type status,
   output mex_pkg::result_type    result_value
);
   import mex_pkg::*;

   localparam int PROD_W  = 2 * MOD_WIDTH;
   localparam int SHIFT_W = BASE_W;
   localparam int STEP_W  = $clog2(SHIFT_W + 1);
   localparam int LEFT_W  = $clog2(EXP_WIDTH + 1);

   logic [EXP_WIDTH-1:0] exp_ff,   exp_in;
   logic [LEFT_W-1:0]    left_ff,  left_in;
   logic [MOD_WIDTH-1:0] base_ff,  base_in;
   logic [MOD_WIDTH-1:0] acc_ff,   acc_in;
   logic [PROD_W-1:0]    prod_ff,  prod_in;
   logic [MOD_WIDTH-1:0] rem_ff,   rem_in;
   logic [SHIFT_W-1:0]   shift_ff, shift_in;
   logic [STEP_W-1:0]    step_ff,  step_in;

   logic [MOD_WIDTH:0]   rem_wide;
   logic [MOD_WIDTH-1:0] rem_sub;
   logic [MOD_WIDTH-1:0] rem_next;
   logic [MOD_WIDTH-1:0] mul_op;
   logic [MOD_WIDTH-1:0] acc_init;

   // One restoring step: shift in the next dividend bit, subtract if it fits
   // (the difference is below the modulus, so its low bits are exact)
   always_comb begin
      rem_wide = {rem_ff, shift_ff[SHIFT_W-1]};
      rem_sub  = rem_wide[MOD_WIDTH-1:0] - modulus;
      rem_next = (rem_wide >= {1'b0, modulus}) ? rem_sub
                                               : rem_wide[MOD_WIDTH-1:0];
   end

   // Running value starts at one, or zero for a unit modulus
   assign acc_init = (modulus == MOD_WIDTH'(1)) ? '0 : MOD_WIDTH'(1);
   assign mul_op   = cmd.mul_by_base ? base_ff : acc_ff;

   // Next register values
   always_comb begin
      exp_in   = exp_ff;
      left_in  = left_ff;
      base_in  = base_ff;
      acc_in   = acc_ff;
      prod_in  = prod_ff;
      rem_in   = rem_ff;
      shift_in = shift_ff;
      step_in  = step_ff;

      if (cmd.load) begin
         exp_in   = EXP_WIDTH'(req_exponent);
         left_in  = LEFT_W'(EXP_WIDTH);
         acc_in   = acc_init;
         rem_in   = '0;
         shift_in = req_base;
         step_in  = STEP_W'(SHIFT_W);
      end
      if (cmd.red_step) begin
         rem_in   = rem_next;
         shift_in = shift_ff << 1;
         step_in  = step_ff - STEP_W'(1);
      end
      if (cmd.base_store) begin
         base_in = rem_ff;
      end
      if (cmd.mul_start) begin
         prod_in = PROD_W'(acc_ff) * PROD_W'(mul_op);
      end
      // upper half of a product of two reduced operands is already below modulus
      if (cmd.prod_load) begin
         rem_in   = prod_ff[PROD_W-1:MOD_WIDTH];
         shift_in = SHIFT_W'(prod_ff[MOD_WIDTH-1:0]) << (SHIFT_W - MOD_WIDTH);
         step_in  = STEP_W'(MOD_WIDTH);
      end
      if (cmd.acc_store) begin
         acc_in = rem_ff;
      end
      if (cmd.bit_next) begin
         exp_in  = exp_ff << 1;
         left_in = left_ff - LEFT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      exp_ff   <= exp_in;
      left_ff  <= left_in;
      base_ff  <= base_in;
      acc_ff   <= acc_in;
      prod_ff  <= prod_in;
      rem_ff   <= rem_in;
      shift_ff <= shift_in;
      step_ff  <= step_in;
   end

   // Status and result
   assign status.red_done = (step_ff == '0);
   assign status.exp_msb  = exp_ff[EXP_WIDTH-1];
   assign status.last_bit = (left_ff == LEFT_W'(1));
   assign status.mod_zero = (modulus == '0);

   assign result_value = status.mod_zero ? '0 : RESULT_W'(acc_ff);

endmodule

### hdl/modular_exponentiation_core.sv
// Top level of the modular exponentiation core: modulus register, output
// register, controller and datapath. Depends on mex_pkg, mex_channels,
// mex_ctrl and mex_datapath.
//
//   Port group   Direction  Carries
//   req_chan     in         base, exponent (valid/ready)
//   rsp_chan     out        result (valid/ready)
//   csr_wr_*     in         modulus write (enable, data)
//
// An item reduces the base, then squares once for each exponent bit and
// multiplies by the base for each set exponent bit; each product is followed
// by a one-bit-per-cycle restoring reduction. A zero modulus skips all of
// this and goes straight to the final state.
// Reset (synchronous) loads the modulus with 1000000009 and empties the
// output register. One item is at work at a time; the next is taken while a
// finished result waits in the output register, and a stalled output holds
// the core in its final state.
module modular_exponentiation_core #(
   parameter int EXP_WIDTH = 32,
   parameter int MOD_WIDTH = 31
) (
   input  logic                 clock,
   input  logic                 reset,
   mex_req_if.sink              req_chan,
   mex_rsp_if.source            rsp_chan,
   input  logic                 csr_wr_en,
   input  mex_pkg::modulus_type csr_wr_data
);
   import mex_pkg::*;

   modulus_type   csr_modulus_ff;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   result_type    rsp_result_ff;

   dp_cmd_type    cmd;
   dp_status_type status;
   result_type    result_value;
   logic          out_free;
   logic          ctrl_ready;

   // Modulus register
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_modulus_ff <= MODULUS_RESET;
      end else if (csr_wr_en) begin
         csr_modulus_ff <= csr_wr_data;
      end
   end

   mex_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .out_free  (out_free),
      .status    (status),
      .req_ready (ctrl_ready),
      .cmd       (cmd)
   );

   mex_datapath #(
      .EXP_WIDTH (EXP_WIDTH),
      .MOD_WIDTH (MOD_WIDTH)
   ) u_datapath (
      .clock        (clock),
      .cmd          (cmd),
      .req_base     (req_chan.base),
      .req_exponent (req_chan.exponent),
      .modulus      (csr_modulus_ff[MOD_WIDTH-1:0]),
      .status       (status),
      .result_value (result_value)
   );

   assign req_chan.ready = ctrl_ready;

   // Output register: free when empty or being taken this cycle
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_result_ff <= result_value;
      end
   end

   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.result = rsp_result_ff;

endmodule

### hdl/mex_checker.sv
// Port-level checks for the modular exponentiation core, bound to the top
// level. Depends on mex_pkg and modular_exponentiation_core.
module mex_checker #(
   parameter int MOD_WIDTH = 31
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input mex_pkg::result_type  rsp_result,
   input logic                 csr_wr_en,
   input mex_pkg::modulus_type csr_wr_data
);
   import mex_pkg::*;

   logic [MOD_WIDTH-1:0] mod_ff;
   logic [1:0]           pending_ff;
   logic [1:0]           pending_in;
   logic                 req_fire;
   logic                 rsp_fire;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   // Track the modulus as written through the port
   always_ff @(posedge clock) begin
      if (reset) begin
         mod_ff <= MODULUS_RESET[MOD_WIDTH-1:0];
      end else if (csr_wr_en) begin
         mod_ff <= csr_wr_data[MOD_WIDTH-1:0];
      end
   end

   // Count items taken but not yet delivered
   always_comb begin
      pending_in = pending_ff;
      if (req_fire && !rsp_fire) begin
         pending_in = pending_ff + 2'd1;
      end else if (!req_fire && rsp_fire) begin
         pending_in = pending_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn while stalled");

   a_result_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (mod_ff == '0 && rsp_result == '0) ||
                    (mod_ff != '0 && rsp_result < RESULT_W'(mod_ff)))
      else $error("result not reduced by the modulus");

   a_rsp_backed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 2'd0)
      else $error("result with no item taken");

   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      pending_ff != 2'd3)
      else $error("more than two items held");

   a_one_at_work: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ready)
      else $error("item taken while another is at work");

endmodule

bind modular_exponentiation_core mex_checker #(
   .MOD_WIDTH (MOD_WIDTH)
) u_mex_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_result  (rsp_chan.result),
   .csr_wr_en   (csr_wr_en),
   .csr_wr_data (csr_wr_data)
);
